// File: rtl/sha1md_pkg.sv
// Shared types, constants and command struct of the SHA-1 message digest block.
// Used by the controller, the datapath and the top level; depends on nothing else.

package sha1md_pkg;

  // Operation codes carried by an input transfer.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Initial chaining values (H0 to H4).
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // Padding marker byte appended after the message.
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Round groups select the boolean function and constant.
  localparam logic [1:0] GRP_CHOOSE   = 2'd0;
  localparam logic [1:0] GRP_PARITY_A = 2'd1;
  localparam logic [1:0] GRP_MAJORITY = 2'd2;
  localparam logic [1:0] GRP_PARITY_B = 2'd3;

  // Source of the byte shifted into the block window.
  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_MARK = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  // Index of the final digest word.
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic       shift_en;   // shift one byte into the block window
    logic [1:0] byte_sel;   // byte source for the shift
    logic [2:0] len_idx;    // byte of the bit length, most significant first
    logic       count_en;   // count one message byte
    logic       load_en;    // copy chaining words into the working variables
    logic       round_en;   // run one compression round
    logic [1:0] rnd_grp;    // group of the current round
    logic       chain_add;  // fold the working variables into the chain
    logic       restart;    // return chain and byte count to initial values
    logic [2:0] out_idx;    // digest word presented on the output
  } sha1md_cmd_t;

endpackage

// File: rtl/sha1md_if.sv
// Valid/ready channel interfaces for the message byte input and the digest output.
// Depends on nothing; used by the top level and by whatever surrounds it.

interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

// File: rtl/sha1_message_digest.sv
// SHA-1 message digest over a byte stream. Each absorb transfer appends one byte; the
// 64th byte of a block starts a compression of 80 rounds (one round per cycle) and a
// fold step, during which the input is not ready, so the throughput of a long message
// is set by the single round unit. A finish transfer pads the block one byte per cycle
// up to its end, runs one or two compressions, then offers the five digest words, H0
// first, the fifth marked last; after the last transfer the block is ready for a new
// message.
// Depends on sha1md_pkg, sha1md_if, sha1md_ctrl and sha1md_dpath.

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sha1md_in_if.sink     msg_in,
  sha1md_out_if.source  dig_out
);

  sha1md_cmd_t cmd;

  // Sequencing of absorb, padding, rounds and output.
  sha1md_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg_in.valid),
    .in_op     (msg_in.op),
    .in_ready  (msg_in.ready),
    .out_valid (dig_out.valid),
    .out_ready (dig_out.ready),
    .cmd       (cmd)
  );

  // Window, round unit and chaining state.
  sha1md_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg_in.data_byte),
    .digest_word (dig_out.digest_word),
    .word_index  (dig_out.word_index),
    .last_word   (dig_out.last_word)
  );

  // No input transfer while a digest word is offered.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    !(msg_in.valid && msg_in.ready && dig_out.valid))
    else $error("input transfer while digest output is valid");

  // A finish transfer always leads into padding or rounds, never straight back to ready.
  a_finish_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (msg_in.valid && msg_in.ready && msg_in.op == OP_FINISH) |=> !msg_in.ready)
    else $error("input ready right after a finish transfer");

  // The output closes after the last digest word is taken.
  a_out_ends: assert property (@(posedge clk) disable iff (rst)
    (dig_out.valid && dig_out.ready && dig_out.last_word) |=> !dig_out.valid)
    else $error("output still valid after the last digest word");

  // Rounds and byte shifts never share a cycle.
  a_round_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.round_en && cmd.shift_en))
    else $error("round and byte shift in the same cycle");

endmodule

// File: rtl/sha1md_ctrl.sv
// Controller of the SHA-1 block: absorb, padding, round sequencing and digest output.
// Depends on sha1md_pkg for the command struct and codes.

module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output sha1md_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [6:0] RND_LAST   = 7'd79;
  localparam logic [6:0] RND_GRP_B  = 7'd20;
  localparam logic [6:0] RND_GRP_C  = 7'd40;
  localparam logic [6:0] RND_GRP_D  = 7'd60;

  logic [2:0] state, state_next;
  logic [5:0] fill, fill_next;
  logic [6:0] rnd, rnd_next;
  logic       finishing, finishing_next;
  logic       len_ok, len_ok_next;
  logic [2:0] oidx, oidx_next;

  // Next-state and command decode.
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    rnd_next       = rnd;
    finishing_next = finishing;
    len_ok_next    = len_ok;
    oidx_next      = oidx;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.out_idx    = oidx;
    cmd.len_idx    = fill[2:0];

    if (rnd < RND_GRP_B) begin
      cmd.rnd_grp = GRP_CHOOSE;
    end else if (rnd < RND_GRP_C) begin
      cmd.rnd_grp = GRP_PARITY_A;
    end else if (rnd < RND_GRP_D) begin
      cmd.rnd_grp = GRP_MAJORITY;
    end else begin
      cmd.rnd_grp = GRP_PARITY_B;
    end

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift_en = 1'b1;
          fill_next    = fill + 6'd1;
          if (in_op == OP_ABSORB) begin
            cmd.byte_sel = SEL_DATA;
            cmd.count_en = 1'b1;
          end else begin
            // The length fits in this block only if the marker lands before it.
            cmd.byte_sel   = SEL_MARK;
            finishing_next = 1'b1;
            len_ok_next    = (fill < FILL_LEN);
            state_next     = ST_PAD;
          end
          if (fill == FILL_LAST) begin
            cmd.load_en = 1'b1;
            rnd_next    = '0;
            state_next  = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = (len_ok && fill >= FILL_LEN) ? SEL_LEN : SEL_ZERO;
        fill_next    = fill + 6'd1;
        if (fill == FILL_LAST) begin
          cmd.load_en = 1'b1;
          rnd_next    = '0;
          state_next  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 7'd1;
        if (rnd == RND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.chain_add = 1'b1;
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_ok) begin
          oidx_next  = '0;
          state_next = ST_OUT;
        end else begin
          // Marker overflowed into the length area: one more padding block.
          len_ok_next = 1'b1;
          state_next  = ST_PAD;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          oidx_next = oidx + 3'd1;
          if (oidx == LAST_WORD_IDX) begin
            cmd.restart    = 1'b1;
            finishing_next = 1'b0;
            oidx_next      = '0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      rnd       <= '0;
      finishing <= 1'b0;
      len_ok    <= 1'b0;
      oidx      <= '0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rnd       <= rnd_next;
      finishing <= finishing_next;
      len_ok    <= len_ok_next;
      oidx      <= oidx_next;
    end
  end

endmodule

// File: rtl/sha1md_dpath.sv
// Datapath of the SHA-1 block: block window with message schedule, round unit,
// chaining words and byte counter. Depends on sha1md_pkg for constants and commands.

module sha1md_dpath
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sha1md_cmd_t cmd,
  input  logic [7:0]  data_byte,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic [31:0] win [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [60:0] count;

  logic [63:0] len_bits;
  logic [7:0]  byte_in;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] t_val;

  // Byte entering the window.
  assign len_bits = {count, 3'b000};
  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_LEN:  byte_in = len_bits[{~cmd.len_idx, 3'b000} +: 8];
      default:  byte_in = '0;
    endcase
  end

  // Next schedule word from the sixteen-word window.
  always_comb begin
    logic [31:0] x;
    x     = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {x[30:0], x[31]};
  end

  // Round function and new working word.
  always_comb begin
    case (cmd.rnd_grp)
      GRP_CHOOSE:   f_val = (b & c) | (~b & d);
      GRP_MAJORITY: f_val = (b & c) | (b & d) | (c & d);
      default:      f_val = b ^ c ^ d;
    endcase
    t_val = {a[26:0], a[31:27]} + f_val + e + K_ROUND[cmd.rnd_grp] + win[0];
  end

  // Block window: bytes shift in big-endian, rounds shift out one word each.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i + 1][31:24]};
      end
      win[15] <= {win[15][23:0], byte_in};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_new;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_en) begin
      a <= t_val;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  // Chaining words and message byte count.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      h     <= H_INIT;
      count <= '0;
    end else begin
      if (cmd.chain_add) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.count_en) begin
        count <= count + 61'd1;
      end
    end
  end

  // Digest word presented on the output.
  assign digest_word = h[cmd.out_idx];
  assign word_index  = cmd.out_idx;
  assign last_word   = (cmd.out_idx == LAST_WORD_IDX);

endmodule

// File: bench/sha1_message_digest_tb.sv
// Self-checking bench for the SHA-1 message digest block: byte messages go in,
// five-word digests come out and are checked against a SHA-1 predictor kept here.
// Depends on sha1md_pkg, sha1md_if and the sha1_message_digest top level.
`timescale 1ns / 100ps

module sha1_message_digest_tb
  import sha1md_pkg::*;
();

  // Own copies of the SHA-1 constants for the predictor.
  localparam logic [31:0] IV_WORDS [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RC_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] RC_PARITY_A = 32'h6ED9EBA1;
  localparam logic [31:0] RC_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] RC_PARITY_B = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam int          DRAIN_CYCLES = 300;

  typedef struct {
    logic       op;
    logic [7:0] data;
    bit         calm;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic clk;
  logic rst;

  sha1md_in_if  msg_in_ch ();
  sha1md_out_if dig_out_ch ();

  sha1_message_digest i_dut (
    .clk     (clk),
    .rst     (rst),
    .msg_in  (msg_in_ch),
    .dig_out (dig_out_ch)
  );

  // Pending message transfers and the digest words still owed by the block.
  msg_item_t    msg_items [$];
  digest_word_t digest_words_due [$];
  int           error_count = 0;

  // Predictor state: chaining words, block buffer, fill and byte count.
  logic [31:0] chain_h [5];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [60:0] msg_bytes;

  logic in_xfer;
  bit   calm_phase = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   in_odds = 0;
  int   out_odds = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function void restart_chain();
    for (int i = 0; i < 5; i++) chain_h[i] = IV_WORDS[i];
    blk_fill = 0;
    msg_bytes = '0;
  endfunction

  // Eighty rounds over the buffered block, folded into the chaining words.
  function void compress_block_bytes();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RC_CHOOSE;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RC_PARITY_A;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = RC_PARITY_B;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function void absorb_msg_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill++;
    msg_bytes++;
    if (blk_fill == 64) begin
      compress_block_bytes();
      blk_fill = 0;
    end
  endfunction

  // Pad the message, compress the last block or two and queue the five words.
  function void pad_and_digest();
    logic [63:0]  bit_len;
    digest_word_t dw;
    bit_len = {msg_bytes, 3'b000};
    blk_bytes[blk_fill] = PAD_BYTE;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      compress_block_bytes();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      blk_bytes[blk_fill] = 8'h00;
      blk_fill++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
    compress_block_bytes();
    for (int i = 0; i < 5; i++) begin
      dw.word = chain_h[i];
      dw.idx  = 3'(i);
      dw.last = (i == 4);
      digest_words_due.insert(digest_words_due.size(), dw);
    end
    restart_chain();
  endfunction

  function void add_item(input logic op, input logic [7:0] b, input bit calm);
    msg_item_t it;
    it.op = op;
    it.data = b;
    it.calm = calm;
    msg_items.insert(msg_items.size(), it);
  endfunction

  // A message of random bytes followed by a finish with a random ignored byte.
  function void add_random_message(input int len, input bit calm);
    for (int i = 0; i < len; i++) add_item(OP_ABSORB, 8'($urandom_range(0, 255)), calm);
    add_item(OP_FINISH, 8'($urandom_range(0, 255)), calm);
  endfunction

  // Idle density for a stretch: zero means no idling at all.
  function int idle_odds_pick();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      2: return 6;
      default: return 20;
    endcase
  endfunction

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitor: note input transfers, run the predictor and check digest words.
  always @(posedge clk) begin
    digest_word_t exp_w;
    in_xfer <= !rst && msg_in_ch.valid && msg_in_ch.ready;
    if (!rst && msg_in_ch.valid && msg_in_ch.ready) begin
      if (msg_in_ch.op == OP_ABSORB) absorb_msg_byte(msg_in_ch.data_byte);
      else pad_and_digest();
    end
    if (!rst && dig_out_ch.valid && dig_out_ch.ready) begin
      if (digest_words_due.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, got word %h index %0d last %0b",
                 $time, dig_out_ch.digest_word, dig_out_ch.word_index, dig_out_ch.last_word);
        error_count++;
      end else begin
        exp_w = digest_words_due.pop_front();
        if (dig_out_ch.digest_word !== exp_w.word) begin
          $display("%0t: digest_word mismatch: expected %h, got %h",
                   $time, exp_w.word, dig_out_ch.digest_word);
          error_count++;
        end
        if (dig_out_ch.word_index !== exp_w.idx) begin
          $display("%0t: word_index mismatch: expected %0d, got %0d",
                   $time, exp_w.idx, dig_out_ch.word_index);
          error_count++;
        end
        if (dig_out_ch.last_word !== exp_w.last) begin
          $display("%0t: last_word mismatch: expected %0b, got %0b",
                   $time, exp_w.last, dig_out_ch.last_word);
          error_count++;
        end
      end
    end
  end

  // Input driver: retires the item taken at the last rising edge, then offers
  // the next one unless an idle burst is running. An offered item is held.
  always @(negedge clk) begin
    if (in_xfer) void'(msg_items.pop_front());
    if ($urandom_range(0, 99) == 0) in_odds = idle_odds_pick();
    if (rst) begin
      msg_in_ch.valid <= 1'b0;
    end else if (msg_in_ch.valid && !in_xfer) begin
      // Offered item not yet taken; keep it on the bus.
    end else if (in_gap != 0) begin
      in_gap--;
      msg_in_ch.valid <= 1'b0;
    end else if (msg_items.size() == 0) begin
      msg_in_ch.valid <= 1'b0;
    end else if (!msg_items[0].calm && in_odds != 0 && $urandom_range(0, in_odds) == 0) begin
      in_gap = $urandom_range(0, 15);
      msg_in_ch.valid <= 1'b0;
    end else begin
      calm_phase = msg_items[0].calm;
      msg_in_ch.valid     <= 1'b1;
      msg_in_ch.op        <= msg_items[0].op;
      msg_in_ch.data_byte <= msg_items[0].data;
    end
  end

  // Output stall driver: ready drops in random bursts until the calm phase.
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) out_odds = idle_odds_pick();
    if (rst) begin
      dig_out_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      dig_out_ch.ready <= 1'b0;
    end else if (!calm_phase && out_odds != 0 && $urandom_range(0, out_odds) == 0) begin
      out_gap = $urandom_range(0, 15);
      dig_out_ch.ready <= 1'b0;
    end else begin
      dig_out_ch.ready <= 1'b1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int bound_lens [9] = '{55, 56, 63, 64, 57, 65, 119, 120, 128};
    int n_rand;
    int n_msgs;
    int len;
    rst = 1'b1;
    in_xfer = 1'b0;
    msg_in_ch.valid = 1'b0;
    msg_in_ch.op = OP_ABSORB;
    msg_in_ch.data_byte = 8'h00;
    dig_out_ch.ready = 1'b0;
    restart_chain();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;

    // Directed: empty message, "abc", extreme bytes, back-to-back finishes.
    add_item(OP_FINISH, 8'h00, 1'b0);
    add_item(OP_ABSORB, 8'h61, 1'b0);
    add_item(OP_ABSORB, 8'h62, 1'b0);
    add_item(OP_ABSORB, 8'h63, 1'b0);
    add_item(OP_FINISH, 8'hFF, 1'b0);
    add_item(OP_ABSORB, 8'h00, 1'b0);
    add_item(OP_ABSORB, 8'hFF, 1'b0);
    add_item(OP_ABSORB, 8'h80, 1'b0);
    add_item(OP_ABSORB, 8'h7F, 1'b0);
    add_item(OP_FINISH, 8'h00, 1'b0);
    add_item(OP_FINISH, 8'h55, 1'b0);
    add_item(OP_ABSORB, 8'h01, 1'b0);
    add_item(OP_FINISH, 8'hAA, 1'b0);

    // Random messages; the first few sit on the padding boundaries.
    n_rand = 0;
    n_msgs = 0;
    while (n_rand < 320 || n_msgs < 12) begin
      if (n_msgs < 4) begin
        len = bound_lens[n_msgs];
      end else begin
        case ($urandom_range(0, 3))
          0, 1: len = $urandom_range(0, 16);
          2: len = bound_lens[$urandom_range(0, 8)];
          default: len = $urandom_range(17, 140);
        endcase
      end
      add_random_message(len, n_rand >= 260);
      n_rand += len + 1;
      n_msgs++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (msg_items.size() != 0 || digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && digest_words_due.size() == 0) begin
      $display("sha1_message_digest_tb passed");
    end else begin
      $display("sha1_message_digest_tb failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("sha1_message_digest_tb failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sha1md_pkg.sv
rtl/sha1md_if.sv
rtl/sha1md_ctrl.sv
rtl/sha1md_dpath.sv
rtl/sha1_message_digest.sv
bench/sha1_message_digest_tb.sv
